[design/form_query_string_parser_core_macros.svh]
// assertion helpers shared by the parser modules
`ifndef FORM_QUERY_STRING_PARSER_CORE_MACROS_SVH
`define FORM_QUERY_STRING_PARSER_CORE_MACROS_SVH

// explicit clock and reset
`define FQSP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// default clock and reset of the parser
`define FQSP_ASSERT(lbl, prop, msg) \
  `FQSP_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[design/fqsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fqsp_pkg;

  localparam int unsigned MaxRes = 4;
  localparam int unsigned NumSlots = 7;
  localparam logic [15:0] MaxPairsRst = 16'd1000;

  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChQuest = 8'h3f;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [1:0] {
    KindKey   = 2'd0,
    KindValue = 2'd1,
    KindEnd   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    HeldNone  = 2'd0,
    HeldPct   = 2'd1,
    HeldDigit = 2'd2
  } held_e;

  typedef enum logic {
    CfgKeepBlank = 1'b0,
    CfgMaxPairs  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic        limit_reached;
    logic        segment_started;
    logic        pair_suppressed;
    logic        in_value_part;
    held_e       held_count;
    logic [7:0]  held_digit;
    logic [15:0] pair_tally;
  } state_t;

  function automatic logic hex_ok(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

[design/fqsp_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module fqsp_step (
  input  fqsp_pkg::state_t                   st_i,
  input  logic [7:0]                         byte_i,
  input  logic                               fin_i,
  input  logic                               keep_blank_i,
  input  logic [15:0]                        max_pairs_i,
  output fqsp_pkg::state_t                   st_o,
  output fqsp_pkg::res_t [fqsp_pkg::MaxRes-1:0] res_o,
  output logic [2:0]                         cnt_o
);
  import fqsp_pkg::*;

  logic [NumSlots-1:0] sv;
  logic [7:0]          sd [NumSlots];
  kind_e               sk [NumSlots];
  state_t              nx;
  logic                consumed;
  logic                flush;
  logic                full;
  kind_e               dk;
  logic [7:0]          dec;

  assign full = st_i.pair_tally >= max_pairs_i;
  assign dec  = {hex_nib(st_i.held_digit), hex_nib(byte_i)};

  always_comb begin
    nx       = st_i;
    consumed = 1'b0;
    flush    = 1'b0;
    dk       = KindKey;
    sv       = '0;
    for (int i = 0; i < NumSlots; i++) begin
      sd[i] = 8'h00;
      sk[i] = KindEnd;
    end
    sd[1] = ChPct;
    sd[2] = st_i.held_digit;
    sd[4] = ChPct;

    if (!st_i.limit_reached) begin
      // segment start or empty segment
      if (!st_i.segment_started) begin
        if (byte_i == ChAmp) begin
          consumed = 1'b1;
          if (keep_blank_i) begin
            if (full) begin
              nx.limit_reached = 1'b1;
            end else begin
              nx.pair_tally      = st_i.pair_tally + 16'd1;
              nx.pair_suppressed = 1'b0;
              sv[0]              = 1'b1;
            end
          end
        end else if (full) begin
          nx.limit_reached = 1'b1;
        end else begin
          nx.pair_tally      = st_i.pair_tally + 16'd1;
          nx.segment_started = 1'b1;
          nx.in_value_part   = 1'b0;
          nx.pair_suppressed = (byte_i == ChEq) && !keep_blank_i;
        end
      end

      if (!nx.limit_reached && nx.segment_started && !consumed) begin
        dk = nx.in_value_part ? KindValue : KindKey;
        sk[1] = dk;
        sk[2] = dk;
        sk[3] = dk;
        if (byte_i == ChAmp) begin
          sv[1] = (st_i.held_count != HeldNone) && !nx.pair_suppressed;
          sv[2] = (st_i.held_count == HeldDigit) && !nx.pair_suppressed;
          sv[6] = !nx.pair_suppressed;
          nx.in_value_part   = 1'b0;
          nx.segment_started = 1'b0;
          nx.pair_suppressed = 1'b0;
          nx.held_count      = HeldNone;
          nx.held_digit      = 8'h00;
        end else begin
          if (st_i.held_count == HeldPct) begin
            if (hex_ok(byte_i)) begin
              nx.held_count = HeldDigit;
              nx.held_digit = byte_i;
              consumed      = 1'b1;
            end else begin
              flush = 1'b1;
            end
          end else if (st_i.held_count == HeldDigit) begin
            if (hex_ok(st_i.held_digit) && hex_ok(byte_i)) begin
              sv[3]         = !nx.pair_suppressed;
              sd[3]         = (dec == 8'h00) ? ChQuest : dec;
              nx.held_count = HeldNone;
              nx.held_digit = 8'h00;
              consumed      = 1'b1;
            end else begin
              flush = 1'b1;
            end
          end
          if (flush) begin
            sv[1]         = !nx.pair_suppressed;
            sv[2]         = (st_i.held_count == HeldDigit) && !nx.pair_suppressed;
            nx.held_count = HeldNone;
            nx.held_digit = 8'h00;
          end
          if (!consumed) begin
            if (byte_i == ChPct) begin
              nx.held_count = HeldPct;
            end else if (byte_i == ChEq && !nx.in_value_part) begin
              nx.in_value_part = 1'b1;
            end else begin
              sv[3] = !nx.pair_suppressed;
              sd[3] = (byte_i == ChPlus) ? ChSpace : byte_i;
            end
          end
          // end of string closes the open segment
          if (fin_i) begin
            sk[4] = nx.in_value_part ? KindValue : KindKey;
            sk[5] = sk[4];
            sd[5] = nx.held_digit;
            sv[4] = (nx.held_count != HeldNone) && !nx.pair_suppressed;
            sv[5] = (nx.held_count == HeldDigit) && !nx.pair_suppressed;
            sv[6] = !nx.pair_suppressed;
          end
        end
      end
    end

    if (fin_i) begin
      nx = '0;
    end
  end

  // pack emitted slots in order, at most four
  always_comb begin
    logic [2:0] n;
    n     = 3'd0;
    res_o = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (sv[i] && n < 3'(MaxRes)) begin
        res_o[n[1:0]] = '{kind: sk[i], data: sd[i]};
        n             = n + 3'd1;
      end
    end
    cnt_o = n;
  end

  assign st_o = nx;

endmodule

`default_nettype wire

[design/fqsp_burst.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "form_query_string_parser_core_macros.svh"

module fqsp_burst (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  fqsp_pkg::res_t [fqsp_pkg::MaxRes-1:0] res_i,
  input  logic [2:0]                         cnt_i,
  output logic                               ready_o,
  output logic                               valid_o,
  input  logic                               take_i,
  output fqsp_pkg::res_t                     res_o,
  output logic                               last_o
);
  import fqsp_pkg::*;

  res_t [MaxRes-1:0] ent_q;
  logic [2:0]        cnt_q, cnt_d;
  logic [1:0]        rd_q, rd_d;
  logic              pop;

  assign valid_o = cnt_q != 3'd0;
  assign pop     = valid_o && take_i;
  assign ready_o = (cnt_q == 3'd0) || (cnt_q == 3'd1 && take_i);
  assign res_o   = ent_q[rd_q];
  assign last_o  = cnt_q == 3'd1;

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load_i) begin
      cnt_d = cnt_i;
      rd_d  = 2'd0;
    end else if (pop) begin
      cnt_d = cnt_q - 3'd1;
      rd_d  = rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      rd_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= res_i;
    end
  end

  `FQSP_ASSERT(a_cnt_range, cnt_q <= 3'(MaxRes), "burst count out of range")
  `FQSP_ASSERT(a_load_cnt, load_i |=> cnt_q == $past(cnt_i), "burst load lost results")
  `FQSP_ASSERT(a_rdy_empty, cnt_q == 3'd0 |-> ready_o, "empty burst buffer not ready")
  `FQSP_ASSERT(a_no_overrun, load_i |-> (cnt_q == 3'd0 || (cnt_q == 3'd1 && take_i)),
               "burst overwritten before drained")

endmodule

`default_nettype wire

[design/form_query_string_parser_core.sv]
// Streaming decoder for URL-encoded query strings. Raw bytes enter on the slave stream, the
// last byte of a string marked by tlast; decoded key bytes, value bytes and pair-end markers
// leave on the master stream, tuser carrying the kind and tlast marking the last result of each
// input byte. One byte is accepted per cycle while every byte yields at most one result and
// the output side is ready; a byte with several results (up to four) lets the next byte in only
// with its last result, as the burst buffer behind the decode logic drains through the single
// output port one result per cycle while that side is ready. keep_blank and max_pairs are
// written through the configuration port by the user only while the stream is idle; unenforced.
`timescale 1ns / 1ps
`default_nettype none

`include "form_query_string_parser_core_macros.svh"

module form_query_string_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,   // is_final
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // run_end
);
  import fqsp_pkg::*;

  logic              keep_blank_q;
  logic [15:0]       max_pairs_q;
  state_t            state_q, state_d;
  res_t [MaxRes-1:0] step_res;
  logic [2:0]        step_cnt;
  res_t              out_res;
  logic              in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  fqsp_step u_step (
    .st_i         (state_q),
    .byte_i       (s_axis_tdata),
    .fin_i        (s_axis_tlast),
    .keep_blank_i (keep_blank_q),
    .max_pairs_i  (max_pairs_q),
    .st_o         (state_d),
    .res_o        (step_res),
    .cnt_o        (step_cnt)
  );

  fqsp_burst u_burst (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_acc),
    .res_i   (step_res),
    .cnt_i   (step_cnt),
    .ready_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .res_o   (out_res),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = out_res.data;
  assign m_axis_tuser = out_res.kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_blank_q <= 1'b0;
      max_pairs_q  <= MaxPairsRst;
      state_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgKeepBlank: keep_blank_q <= cfg_data_i[0];
          CfgMaxPairs:  max_pairs_q  <= cfg_data_i;
          default:      ;
        endcase
      end
      if (in_acc) begin
        state_q <= state_d;
      end
    end
  end

  `FQSP_ASSERT(a_lim_holds, state_q.limit_reached && !(in_acc && s_axis_tlast) |=>
               state_q.limit_reached, "limit dropped inside a string")
  `FQSP_ASSERT(a_lim_silent, in_acc && state_q.limit_reached |=> !m_axis_tvalid,
               "output after pair limit")
  `FQSP_ASSERT(a_final_clears, in_acc && s_axis_tlast |=> state_q == '0,
               "string state kept past final byte")

endmodule

`default_nettype wire
